// ===== design/hcmf_pkg.sv =====
// Package of the hash chain match finder: opcodes, payload and queue types,
// shared constants and the length saturation helper.
// No dependencies.
package hcmf_pkg;

	localparam int BLOCK_BYTES      = 65536;
	localparam int CHAIN_ENTRIES    = 65536;
	localparam int HASH_ENTRIES_DEF = 32768;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [31:0] HASH_MULT   = 32'd2246822519;
	localparam logic [15:0] NICE_OFFSET = 16'd64;
	localparam logic [17:0] FIRST_BEST  = 18'd3;
	localparam logic [16:0] END_SLACK   = 17'd7;
	localparam logic [12:0] MAXIT_RESET = 13'd256;
	localparam logic [17:0] MIN_MATCH   = 18'd4;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_INDEX = 2'd1,
		OP_FIRST = 2'd2,
		OP_EXT   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [15:0] position;
		logic [7:0]  data_byte;
		logic [15:0] literal_start;
		logic [15:0] match_end;
	} req_t;

	typedef struct packed {
		logic [15:0] match_length;
		logic [15:0] match_start;
		logic [15:0] match_offset;
	} rsp_t;

	typedef struct packed {
		logic [12:0] max_iterations;
	} cfg_t;

	// Queue entry: the request with its byte limit already worked out.
	typedef struct packed {
		op_t         op;
		logic [15:0] pos;
		logic [7:0]  data;
		logic [15:0] lit;
		logic [16:0] limit;
	} item_t;

	typedef struct packed {
		logic pop;
		logic init_done;
	} status_t;

	function automatic logic [15:0] sat16(input logic [17:0] v);
		logic [15:0] r;
		r = (v > 18'h0ffff) ? 16'hffff : v[15:0];
		return r;
	endfunction

endpackage

// ===== design/hcmf_chan_if.sv =====
// Valid/ready channel used for requests, results and the configuration write.
// Depends on nothing; the payload type is a parameter.
interface hcmf_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/hcmf_front.sv =====
// Front end: accepts request items, works out the byte limit and holds them
// in a short queue for the back end. Depends on hcmf_pkg and hcmf_chan_if.
module hcmf_front (
	input  logic                clk,
	input  logic                arst_n,
	hcmf_chan_if.sink           req,
	input  hcmf_pkg::status_t   st,
	output logic                q_valid,
	output hcmf_pkg::item_t     q_item
);
	localparam int PW = $clog2(hcmf_pkg::QUEUE_DEPTH);
	localparam logic [PW:0] FULL = (PW + 1)'(hcmf_pkg::QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST = PW'(hcmf_pkg::QUEUE_DEPTH - 1);

	hcmf_pkg::item_t fifo_q [hcmf_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            push;
	hcmf_pkg::item_t item_in;

	assign req.ready = st.init_done && (cnt_q != FULL);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = fifo_q[rd_q];

	always_comb begin
		item_in.op    = req.data.opcode;
		item_in.pos   = req.data.position;
		item_in.data  = req.data.data_byte;
		item_in.lit   = req.data.literal_start;
		item_in.limit = {1'b0, req.data.match_end} + hcmf_pkg::END_SLACK;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (st.pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push, st.pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== design/hcmf_back.sv =====
// Back end: history, head and chain memories and the sequencer that carries
// out loads, index runs and chain searches. Depends on hcmf_pkg, hcmf_chan_if.
module hcmf_back #(
	parameter int HASH_ENTRIES = hcmf_pkg::HASH_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  hcmf_pkg::item_t   q_item,
	output hcmf_pkg::status_t st,
	hcmf_chan_if.sink         cfg,
	hcmf_chan_if.source       rsp
);
	localparam int HASH_BITS = $clog2(HASH_ENTRIES + 1) - 1;
	localparam int HEAD_AW   = $clog2(HASH_ENTRIES);
	localparam logic [16:0] HEAD_END  = 17'(HASH_ENTRIES);
	localparam logic [15:0] CLEAR_END = 16'(hcmf_pkg::CHAIN_ENTRIES - 1);

	typedef enum logic [17:0] {
		S_INIT   = 18'h00001,
		S_IDLE   = 18'h00002,
		S_LOAD   = 18'h00004,
		S_RD0    = 18'h00008,
		S_RD1    = 18'h00010,
		S_MUL    = 18'h00020,
		S_HEAD   = 18'h00040,
		S_HWAIT  = 18'h00080,
		S_CAND   = 18'h00100,
		S_CISS   = 18'h00200,
		S_CCHK   = 18'h00400,
		S_MATCH  = 18'h00800,
		S_BISS   = 18'h01000,
		S_BCHK   = 18'h02000,
		S_UPD    = 18'h04000,
		S_NEXT   = 18'h08000,
		S_CHWAIT = 18'h10000,
		S_FIN    = 18'h20000
	} state_t;

	logic [7:0]  hist_mem  [hcmf_pkg::BLOCK_BYTES];
	logic [15:0] head_mem  [HASH_ENTRIES];
	logic [15:0] chain_mem [hcmf_pkg::CHAIN_ENTRIES];

	state_t          state_q;
	logic [15:0]     clr_q;
	hcmf_pkg::item_t item_q;
	logic [12:0]     maxit_q;
	logic [16:0]     next_q;
	logic [15:0]     p_q;
	logic [7:0]      b0_q, b1_q;
	logic [31:0]     prod_q;
	logic [15:0]     mpos_q;
	logic [13:0]     budget_q;
	logic [17:0]     len_q, cnt_q;
	logic [15:0]     start_q, off_q, r_q;
	logic [16:0]     s_q;
	logic            probe_q;
	logic            rsp_valid_q;
	hcmf_pkg::rsp_t  rsp_q;

	logic [7:0]  ha_q, hb_q;
	logic [15:0] head_rd_q, chain_rd_q;

	logic [15:0]         base, ra, rb;
	logic [HASH_BITS-1:0] hash_now;
	logic                head_we, chain_we;
	logic [HEAD_AW-1:0]  head_wa;
	logic [15:0]         head_wd, chain_wa, chain_wd;
	logic                is_index, is_first, eq, fwd_stop;
	logic [17:0]         probe;
	logic [15:0]         probe_s, probe_r;

	assign is_index = (item_q.op == hcmf_pkg::OP_INDEX);
	assign is_first = (item_q.op == hcmf_pkg::OP_FIRST);
	assign base     = is_index ? p_q : item_q.pos;
	assign hash_now = prod_q[31 -: HASH_BITS];
	assign eq       = (ha_q == hb_q);
	// The first four bytes are compared without regard to the end limit.
	assign fwd_stop = !probe_q && (cnt_q >= hcmf_pkg::MIN_MATCH) && (s_q >= item_q.limit);
	assign probe    = len_q + ((off_q >= hcmf_pkg::NICE_OFFSET) ? 18'd1 : 18'd0);
	assign probe_s  = item_q.pos + probe[15:0] - 16'd4;
	assign probe_r  = mpos_q + probe[15:0] - 16'd4;

	assign st.pop       = (state_q == S_IDLE) && q_valid;
	assign st.init_done = (state_q != S_INIT);
	assign cfg.ready    = 1'b1;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.data     = rsp_q;

	always_comb begin
		case (state_q)
			S_RD0: begin
				ra = base;
				rb = base + 16'd1;
			end
			S_RD1: begin
				ra = base + 16'd2;
				rb = base + 16'd3;
			end
			S_BISS: begin
				ra = r_q - 16'd1;
				rb = s_q[15:0] - 16'd1;
			end
			default: begin
				ra = r_q;
				rb = s_q[15:0];
			end
		endcase
	end

	always_comb begin
		head_we  = 1'b0;
		head_wa  = HEAD_AW'(hash_now);
		head_wd  = p_q;
		chain_we = 1'b0;
		chain_wa = p_q;
		chain_wd = p_q - head_rd_q;
		if (state_q == S_INIT) begin
			head_we  = ({1'b0, clr_q} < HEAD_END);
			head_wa  = clr_q[HEAD_AW-1:0];
			head_wd  = '0;
			chain_we = 1'b1;
			chain_wa = clr_q;
			chain_wd = 16'hffff;
		end else if (state_q == S_HWAIT && is_index) begin
			head_we  = 1'b1;
			chain_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			hist_mem[item_q.pos] <= item_q.data;
		end
		ha_q <= hist_mem[ra];
		hb_q <= hist_mem[rb];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem[HEAD_AW'(hash_now)];
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[chain_wa] <= chain_wd;
		end
		chain_rd_q <= chain_mem[mpos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			item_q      <= '0;
			maxit_q     <= hcmf_pkg::MAXIT_RESET;
			next_q      <= '0;
			p_q         <= '0;
			b0_q        <= '0;
			b1_q        <= '0;
			prod_q      <= '0;
			mpos_q      <= '0;
			budget_q    <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			start_q     <= '0;
			off_q       <= '0;
			r_q         <= '0;
			s_q         <= '0;
			probe_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg.valid) begin
				maxit_q <= cfg.data.max_iterations;
			end
			if (rsp_valid_q && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 16'd1;
					if (clr_q == CLEAR_END) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						len_q   <= '0;
						start_q <= '0;
						off_q   <= '0;
						p_q     <= next_q[15:0];
						case (q_item.op)
							hcmf_pkg::OP_LOAD:  state_q <= S_LOAD;
							hcmf_pkg::OP_INDEX: begin
								state_q <= ({1'b0, q_item.pos} >= next_q) ? S_RD0 : S_FIN;
							end
							default:            state_q <= S_RD0;
						endcase
					end
				end
				S_LOAD:  state_q <= S_FIN;
				S_RD0:   state_q <= S_RD1;
				S_RD1: begin
					b0_q    <= ha_q;
					b1_q    <= hb_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= {hb_q, ha_q, b1_q, b0_q} * hcmf_pkg::HASH_MULT;
					state_q <= S_HEAD;
				end
				S_HEAD:  state_q <= S_HWAIT;
				S_HWAIT: begin
					if (is_index) begin
						p_q <= p_q + 16'd1;
						if (p_q == item_q.pos) begin
							next_q  <= {1'b0, item_q.pos} + 17'd1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_RD0;
						end
					end else begin
						mpos_q  <= head_rd_q;
						start_q <= item_q.pos;
						if (is_first) begin
							len_q    <= hcmf_pkg::FIRST_BEST;
							off_q    <= hcmf_pkg::NICE_OFFSET;
							budget_q <= {maxit_q, 1'b0};
						end else begin
							budget_q <= {1'b0, maxit_q};
						end
						state_q <= S_CAND;
					end
				end
				S_CAND: begin
					cnt_q <= '0;
					if (mpos_q < item_q.pos) begin
						if (is_first) begin
							probe_q <= 1'b1;
							s_q     <= {1'b0, probe_s};
							r_q     <= probe_r;
						end else begin
							probe_q <= 1'b0;
							s_q     <= {1'b0, item_q.pos};
							r_q     <= mpos_q;
						end
						state_q <= S_CISS;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_CISS:  state_q <= fwd_stop ? S_MATCH : S_CCHK;
				S_CCHK: begin
					if (eq) begin
						if (probe_q && cnt_q == 18'd3) begin
							// Probe passed: restart at the candidate's first byte.
							probe_q <= 1'b0;
							cnt_q   <= '0;
							s_q     <= {1'b0, item_q.pos};
							r_q     <= mpos_q;
						end else begin
							cnt_q <= cnt_q + 18'd1;
							s_q   <= s_q + 17'd1;
							r_q   <= r_q + 16'd1;
						end
						state_q <= S_CISS;
					end else if (probe_q || cnt_q < hcmf_pkg::MIN_MATCH) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (is_first) begin
						if (cnt_q >= len_q) begin
							off_q <= item_q.pos - mpos_q;
							len_q <= cnt_q;
						end
						state_q <= S_NEXT;
					end else begin
						s_q     <= {1'b0, item_q.pos};
						r_q     <= mpos_q;
						state_q <= S_BISS;
					end
				end
				S_BISS:  state_q <= (r_q == '0) ? S_UPD : S_BCHK;
				S_BCHK: begin
					if (eq) begin
						s_q   <= s_q - 17'd1;
						r_q   <= r_q - 16'd1;
						cnt_q <= cnt_q + 18'd1;
						state_q <= ((s_q - 17'd1) > {1'b0, item_q.lit}) ? S_BISS : S_UPD;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (cnt_q >= len_q && !(cnt_q == len_q && start_q <= s_q[15:0]
							&& off_q >= hcmf_pkg::NICE_OFFSET)) begin
						start_q <= s_q[15:0];
						off_q   <= s_q[15:0] - r_q;
						len_q   <= cnt_q;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (budget_q <= 14'd1) begin
						state_q <= S_FIN;
					end else begin
						budget_q <= budget_q - 14'd1;
						state_q  <= S_CHWAIT;
					end
				end
				S_CHWAIT: begin
					if (chain_rd_q > mpos_q) begin
						state_q <= S_FIN;
					end else begin
						mpos_q  <= mpos_q - chain_rd_q;
						state_q <= S_CAND;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.match_length <= hcmf_pkg::sat16(len_q);
						rsp_q.match_start  <= start_q;
						rsp_q.match_offset <= off_q;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end
endmodule

// ===== design/hash_chain_match_finder.sv =====
// Hash chain match finder. Items are carried out one at a time. A load writes one byte,
// an index run hashes and links each position in turn, and a search walks the chain,
// per candidate stepping the chain, comparing byte pairs and scoring a match.
// The sequencer reads the byte pairs from its two-port history memory.
// After reset a clearing pass sets the head and chain tables;
// no item is accepted until it ends. Configuration writes are taken at any time.
module hash_chain_match_finder #(
	parameter int HASH_ENTRIES = hcmf_pkg::HASH_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hcmf_chan_if.sink   req,
	hcmf_chan_if.source rsp,
	hcmf_chan_if.sink   cfg
);
	hcmf_pkg::status_t st;
	logic              q_valid;
	hcmf_pkg::item_t   q_item;

	hcmf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.st      (st),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	hcmf_back #(
		.HASH_ENTRIES (HASH_ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.st      (st),
		.cfg     (cfg),
		.rsp     (rsp)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!st.init_done |-> !req.ready)
		else $error("item accepted during table clearing");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		st.pop |-> q_valid)
		else $error("queue popped while empty");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		st.init_done |=> st.init_done)
		else $error("clearing pass restarted without reset");
endmodule

// ===== sim/hash_chain_match_finder_test.sv =====
`timescale 1ns / 1ps
// Testbench of hash_chain_match_finder: directed and random loads, index runs and
// both searches, each result checked against a predictor kept in this file.
// Depends on hash_chain_match_finder, hcmf_pkg and hcmf_chan_if.
module hash_chain_match_finder_test;

	localparam int IDLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;

	hcmf_chan_if #(.T(hcmf_pkg::req_t)) req_ch ();
	hcmf_chan_if #(.T(hcmf_pkg::rsp_t)) rsp_ch ();
	hcmf_chan_if #(.T(hcmf_pkg::cfg_t)) cfg_ch ();

	hash_chain_match_finder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted state of the block.
	logic [7:0]  hist [hcmf_pkg::BLOCK_BYTES];
	logic [15:0] heads [hcmf_pkg::HASH_ENTRIES_DEF];
	logic [15:0] links [hcmf_pkg::CHAIN_ENTRIES];
	int unsigned next_pos;
	int unsigned iter_budget;

	hcmf_pkg::rsp_t pending_matches [$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	// Bytes 0 .. filled-1 are written; random stimulus never reads above them.
	int unsigned filled = 0;
	int copy_left = 0;
	int unsigned copy_dist = 1;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] word_at(int unsigned a);
		return {hist[(a + 3) & 16'hffff], hist[(a + 2) & 16'hffff],
			hist[(a + 1) & 16'hffff], hist[a & 16'hffff]};
	endfunction

	function automatic int unsigned hash_of(logic [31:0] w);
		logic [31:0] prod;
		prod = w * hcmf_pkg::HASH_MULT;
		return prod >> 17;
	endfunction

	function automatic int unsigned run_length(int unsigned s, int unsigned r,
			int unsigned lim);
		int unsigned n;
		n = 0;
		while (s < lim && hist[s & 16'hffff] == hist[r & 16'hffff]) begin
			s++;
			r++;
			n++;
		end
		return n;
	endfunction

	function automatic hcmf_pkg::rsp_t predict_match(hcmf_pkg::req_t it);
		hcmf_pkg::rsp_t res;
		int unsigned pos, lim, len, start, off, mpos, h, m, s, r, probe, d;
		logic [31:0] cur;
		int budget;
		pos = it.position;
		lim = it.match_end + 7;
		len = 0;
		start = 0;
		off = 0;
		case (it.opcode)
			hcmf_pkg::OP_LOAD: hist[pos] = it.data_byte;
			hcmf_pkg::OP_INDEX: begin
				for (int unsigned p = next_pos; p < pos + 1; p++) begin
					h = hash_of(word_at(p));
					d = p - heads[h];
					links[p & 16'hffff] = (d > 16'hffff) ? 16'hffff : d[15:0];
					heads[h] = p[15:0];
				end
				if (pos + 1 > next_pos)
					next_pos = pos + 1;
			end
			default: begin
				cur = word_at(pos);
				mpos = heads[hash_of(cur)];
				budget = iter_budget;
				start = pos;
				if (it.opcode == hcmf_pkg::OP_FIRST) begin
					len = hcmf_pkg::FIRST_BEST;
					off = hcmf_pkg::NICE_OFFSET;
					budget = budget * 2;
				end
				forever begin
					if (it.opcode == hcmf_pkg::OP_FIRST) begin
						if (mpos < pos) begin
							probe = len + ((off >= hcmf_pkg::NICE_OFFSET) ? 1 : 0);
							if (word_at(mpos + probe - 4) == word_at(pos + probe - 4) &&
									word_at(mpos) == cur) begin
								m = 4 + run_length(pos + 4, mpos + 4, lim);
								if (m >= len) begin
									off = pos - mpos;
									len = m;
								end
							end
						end
					end else if (mpos < pos && word_at(mpos) == cur) begin
						m = 4 + run_length(pos + 4, mpos + 4, lim);
						s = pos;
						r = mpos;
						// Backward extension tries at least one step, unless the candidate is at byte 0.
						do begin
							if (r == 0)
								break;
							if (hist[(s - 1) & 16'hffff] != hist[(r - 1) & 16'hffff])
								break;
							s--;
							r--;
							m++;
						end while (s > it.literal_start);
						if (m >= len && !(m == len && start <= s &&
								off >= hcmf_pkg::NICE_OFFSET)) begin
							start = s;
							off = s - r;
							len = m;
						end
					end
					budget--;
					if (budget <= 0)
						break;
					d = links[mpos & 16'hffff];
					if (d > mpos)
						break;
					mpos = mpos - d;
				end
			end
		endcase
		res.match_length = (len > 16'hffff) ? 16'hffff : len[15:0];
		res.match_start = start[15:0];
		res.match_offset = off[15:0];
		return res;
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_item(hcmf_pkg::req_t it);
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_matches.push_back(predict_match(it));
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
		end
	endtask

	task automatic drain_matches();
		req_ch.valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_iterations(logic [12:0] v);
		drain_matches();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{max_iterations: v};
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		iter_budget = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic hcmf_pkg::req_t make_req(hcmf_pkg::op_t op, int unsigned pos,
			int unsigned b, int unsigned lit, int unsigned mend);
		hcmf_pkg::req_t it;
		it.opcode = op;
		it.position = pos[15:0];
		it.data_byte = b[7:0];
		it.literal_start = lit[15:0];
		it.match_end = mend[15:0];
		return it;
	endfunction

	task automatic test_directed();
		logic [7:0] pat [4];
		pat = '{8'h00, 8'hff, 8'h5a, 8'h00};
		for (int unsigned i = 0; i < 16; i++)
			send_item(make_req(hcmf_pkg::OP_LOAD, i, pat[i % 4], 16'hffff, 16'hffff));
		filled = 16;
		send_item(make_req(hcmf_pkg::OP_LOAD, 65532, 8'hff, 0, 0));
		send_item(make_req(hcmf_pkg::OP_LOAD, 65533, 8'h00, 0, 0));
		send_item(make_req(hcmf_pkg::OP_LOAD, 65534, 8'ha5, 0, 0));
		send_item(make_req(hcmf_pkg::OP_LOAD, 65535, 8'h5a, 0, 0));
		send_item(make_req(hcmf_pkg::OP_INDEX, 11, 0, 0, 0));
		// Index request behind the indexed front does nothing.
		send_item(make_req(hcmf_pkg::OP_INDEX, 3, 8'hff, 16'hffff, 16'hffff));
		send_item(make_req(hcmf_pkg::OP_FIRST, 12, 0, 0, 8));
		send_item(make_req(hcmf_pkg::OP_EXT, 12, 0, 0, 8));
		send_item(make_req(hcmf_pkg::OP_EXT, 12, 0, 16'hffff, 8));
		send_item(make_req(hcmf_pkg::OP_EXT, 0, 0, 0, 0));
		send_item(make_req(hcmf_pkg::OP_FIRST, 65535, 0, 0, 0));
		send_item(make_req(hcmf_pkg::OP_EXT, 65535, 0, 65535, 0));
	endtask

	function automatic logic [7:0] next_byte();
		int unsigned k;
		if (copy_left == 0 && $urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, 2);
			copy_dist = (k == 0) ? $urandom_range(1, 8) :
				(k == 1) ? $urandom_range(60, 70) : $urandom_range(100, 300);
			if (copy_dist > filled)
				copy_dist = filled;
			copy_left = $urandom_range(4, 40);
		end
		if (copy_left > 0) begin
			copy_left--;
			return hist[filled - copy_dist];
		end
		k = $urandom_range(0, 9);
		return (k < 3) ? 8'h00 : (k < 6) ? 8'hff : (k < 8) ? 8'h3c : 8'($urandom);
	endfunction

	task automatic test_random_phase(int n);
		int unsigned k, pos, mend, lit, lo;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 40 || filled < 24) begin
				send_item(make_req(hcmf_pkg::OP_LOAD, filled, next_byte(), $urandom,
					$urandom));
				filled++;
			end else if (k < 45) begin
				send_item(make_req(hcmf_pkg::OP_LOAD, $urandom_range(0, filled - 1),
					$urandom, $urandom, $urandom));
			end else if (k < 62) begin
				if (next_pos + 3 < filled && $urandom_range(0, 3) != 0)
					pos = $urandom_range(next_pos, filled - 4);
				else
					pos = (next_pos == 0) ? 0 : $urandom_range(0, next_pos - 1);
				send_item(make_req(hcmf_pkg::OP_INDEX, pos, $urandom, $urandom, $urandom));
			end else begin
				lo = (next_pos > 40) ? next_pos - 40 : 0;
				if (lo > filled - 5)
					lo = 0;
				pos = ($urandom_range(0, 3) != 0) ? $urandom_range(lo, filled - 5) :
					$urandom_range(0, filled - 5);
				mend = ($urandom_range(0, 3) != 0) ? filled - 8 : $urandom_range(0, filled - 8);
				lit = ($urandom_range(0, 5) != 0) ? $urandom_range(0, pos) : $urandom_range(0, 65535);
				send_item(make_req($urandom_range(0, 1) ? hcmf_pkg::OP_FIRST : hcmf_pkg::OP_EXT,
					pos, $urandom, lit, mend));
			end
		end
	endtask

	task automatic test_iteration_settings();
		logic [12:0] settings [6];
		settings = '{13'd1, 13'd4096, 13'd0, 13'd8191, hcmf_pkg::MAXIT_RESET, 13'd3};
		foreach (settings[i]) begin
			write_iterations(settings[i]);
			test_random_phase(120);
		end
		write_iterations(13'($urandom_range(1, 4096)));
		test_random_phase(110);
		drain_matches();
	endtask

	// Receiver stall pattern: modes of random length.
	int ready_mode = 0;
	int ready_left = 0;
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(5, 60);
		end
		ready_left--;
		case (ready_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= $urandom_range(0, 1);
			2: rsp_ch.ready <= ready_left[0];
			default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		hcmf_pkg::rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_matches.size() == 0) begin
				$error("result with no expectation: length %0d start %0d offset %0d",
					rsp_ch.data.match_length, rsp_ch.data.match_start,
					rsp_ch.data.match_offset);
				errors++;
			end else begin
				want = pending_matches.pop_front();
				if (rsp_ch.data.match_length !== want.match_length) begin
					$error("match_length expected %0d actual %0d", want.match_length,
						rsp_ch.data.match_length);
					errors++;
				end
				if (rsp_ch.data.match_start !== want.match_start) begin
					$error("match_start expected %0d actual %0d", want.match_start,
						rsp_ch.data.match_start);
					errors++;
				end
				if (rsp_ch.data.match_offset !== want.match_offset) begin
					$error("match_offset expected %0d actual %0d", want.match_offset,
						rsp_ch.data.match_offset);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** hash_chain_match_finder: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		foreach (hist[i])
			hist[i] = 8'h00;
		foreach (heads[i])
			heads[i] = 16'h0000;
		foreach (links[i])
			links[i] = 16'hffff;
		next_pos = 0;
		iter_budget = hcmf_pkg::MAXIT_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_iteration_settings();
		repeat (50) @(posedge clk);
		if (pending_matches.size() != 0) begin
			$error("%0d expected results never arrived", pending_matches.size());
			errors++;
		end
		if (errors == 0)
			$display("** hash_chain_match_finder: PASSED **");
		else
			$display("** hash_chain_match_finder: FAILED **");
		$finish;
	end

endmodule
